// ===== sv/chs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int ALPHA_BITS        = 16;
    localparam int ANGLE_W           = 12;
    localparam int RAW_W             = 16;
    localparam int TILT_W            = 8;
    localparam int OFFSET_W          = 12;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_INDEX_W       = 2;

    localparam int FULL_TURN_TENTHS  = 3600;
    localparam int HALF_TURN_TENTHS  = 1800;
    localparam int MAX_RAW_TENTHS    = 3599;

    localparam logic [CFG_INDEX_W-1:0] CFG_MOUNT_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA        = 2'd1;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'hFFFF;

endpackage

`default_nettype wire

// ===== sv/circular_heading_smoother_top.sv =====
// Each request passes from the input register to the result register when out_free.
// Throughput: one request per cycle unless the output stalls; the heading update (wrapped
// difference, one multiply, add and wrap) is combinational between input and result registers.
// Reset: synchronous, active low; clears valid flags, filter state and extremes,
// offset to 0 and alpha to 65535. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module circular_heading_smoother_top #(
    parameter int FRACTION_BITS = chs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [chs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [chs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [chs_pkg::RAW_W-1:0]           i_raw_angle_tenths,
    input  wire logic signed [chs_pkg::TILT_W-1:0]   i_pitch_degrees,
    input  wire logic signed [chs_pkg::TILT_W-1:0]   i_roll_degrees,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [chs_pkg::ANGLE_W-1:0]              o_heading_tenths,
    output logic signed [chs_pkg::TILT_W-1:0]        o_pitch_now,
    output logic signed [chs_pkg::TILT_W-1:0]        o_roll_now,
    output logic signed [chs_pkg::TILT_W-1:0]        o_pitch_highest,
    output logic signed [chs_pkg::TILT_W-1:0]        o_pitch_lowest,
    output logic signed [chs_pkg::TILT_W-1:0]        o_roll_highest,
    output logic signed [chs_pkg::TILT_W-1:0]        o_roll_lowest
);
    import chs_pkg::*;

    localparam int HW = ANGLE_W + FRACTION_BITS;
    localparam int DW = HW + 2;
    localparam int AW = ANGLE_W + 2;

    localparam logic signed [DW-1:0] FULL_FX =
        DW'(longint'(FULL_TURN_TENTHS) << FRACTION_BITS);
    localparam logic signed [DW-1:0] HALF_FX =
        DW'(longint'(HALF_TURN_TENTHS) << FRACTION_BITS);
    localparam logic signed [AW-1:0] FULL_A = AW'(FULL_TURN_TENTHS);
    localparam logic [ANGLE_W-1:0]   MAX_RAW = ANGLE_W'(MAX_RAW_TENTHS);

    // configuration
    logic signed [OFFSET_W-1:0] r_offset;
    logic [ALPHA_BITS-1:0]      r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_alpha  <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MOUNT_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_ALPHA:        r_alpha  <= i_cfg_data[ALPHA_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic                      r_s1_valid;
    logic [RAW_W-1:0]          r_s1_raw;
    logic signed [TILT_W-1:0]  r_s1_pitch;
    logic signed [TILT_W-1:0]  r_s1_roll;
    logic                      out_free;
    logic                      s1_move;

    assign out_free   = !o_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_raw   <= i_raw_angle_tenths;
            r_s1_pitch <= i_pitch_degrees;
            r_s1_roll  <= i_roll_degrees;
        end
    end

    // filter state
    logic [HW-1:0]            r_h;
    logic                     r_heading_valid;
    logic                     r_ext_valid;
    logic signed [TILT_W-1:0] r_pitch_max;
    logic signed [TILT_W-1:0] r_pitch_min;
    logic signed [TILT_W-1:0] r_roll_max;
    logic signed [TILT_W-1:0] r_roll_min;

    logic [ANGLE_W-1:0]            raw_c;
    logic signed [AW-1:0]          angle;
    logic signed [AW-1:0]          angle_w;
    logic [HW-1:0]                 target;
    logic signed [DW-1:0]          diff;
    logic signed [DW-1:0]          diff_w;
    logic signed [DW+ALPHA_BITS:0] prod;
    logic signed [DW-1:0]          step;
    logic signed [DW-1:0]          h_sum;
    logic signed [DW-1:0]          h_wrap;
    logic [HW-1:0]                 n_h;
    logic signed [TILT_W-1:0]      n_pitch_max;
    logic signed [TILT_W-1:0]      n_pitch_min;
    logic signed [TILT_W-1:0]      n_roll_max;
    logic signed [TILT_W-1:0]      n_roll_min;

    always_comb begin
        raw_c = (r_s1_raw > RAW_W'(MAX_RAW_TENTHS)) ? MAX_RAW : r_s1_raw[ANGLE_W-1:0];
        angle = signed'({2'b00, raw_c}) + AW'(r_offset);
        angle_w = angle;
        if (angle_w >= FULL_A) begin
            angle_w = angle_w - FULL_A;
        end
        if (angle_w < 0) begin
            angle_w = angle_w + FULL_A;
        end
        target = {angle_w[ANGLE_W-1:0], {FRACTION_BITS{1'b0}}};

        diff = signed'({2'b00, target}) - signed'({2'b00, r_h});
        diff_w = diff;
        if (diff_w > HALF_FX) begin
            diff_w = diff_w - FULL_FX;
        end
        if (diff_w < -HALF_FX) begin
            diff_w = diff_w + FULL_FX;
        end
        // floor rounding of the scaled step falls out of the arithmetic shift
        prod = diff_w * signed'({1'b0, r_alpha});
        step = prod[ALPHA_BITS +: DW];
        h_sum = signed'({2'b00, r_h}) + step;
        h_wrap = h_sum;
        if (h_wrap >= FULL_FX) begin
            h_wrap = h_wrap - FULL_FX;
        end
        if (h_wrap < 0) begin
            h_wrap = h_wrap + FULL_FX;
        end
        n_h = r_heading_valid ? h_wrap[HW-1:0] : target;

        if (!r_ext_valid) begin
            n_pitch_max = r_s1_pitch;
            n_pitch_min = r_s1_pitch;
            n_roll_max  = r_s1_roll;
            n_roll_min  = r_s1_roll;
        end else begin
            n_pitch_max = (r_s1_pitch > r_pitch_max) ? r_s1_pitch : r_pitch_max;
            n_pitch_min = (r_s1_pitch < r_pitch_min) ? r_s1_pitch : r_pitch_min;
            n_roll_max  = (r_s1_roll > r_roll_max) ? r_s1_roll : r_roll_max;
            n_roll_min  = (r_s1_roll < r_roll_min) ? r_s1_roll : r_roll_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h             <= '0;
            r_heading_valid <= 1'b0;
            r_ext_valid     <= 1'b0;
            r_pitch_max     <= '0;
            r_pitch_min     <= '0;
            r_roll_max      <= '0;
            r_roll_min      <= '0;
        end else if (s1_move) begin
            r_h             <= n_h;
            r_heading_valid <= 1'b1;
            r_ext_valid     <= 1'b1;
            r_pitch_max     <= n_pitch_max;
            r_pitch_min     <= n_pitch_min;
            r_roll_max      <= n_roll_max;
            r_roll_min      <= n_roll_min;
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_heading_tenths <= n_h[HW-1:FRACTION_BITS];
            o_pitch_now      <= r_s1_pitch;
            o_roll_now       <= r_s1_roll;
            o_pitch_highest  <= n_pitch_max;
            o_pitch_lowest   <= n_pitch_min;
            o_roll_highest   <= n_roll_max;
            o_roll_lowest    <= n_roll_min;
        end
    end

    assign o_out_valid = r_out_valid;

    a_heading_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        signed'({2'b00, r_h}) < FULL_FX)
        else $error("smoothed heading left the circle");

    a_extremes_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch_lowest <= o_pitch_highest) &&
                        (o_roll_lowest <= o_roll_highest))
        else $error("extremes out of order");

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading_valid |=> r_heading_valid)
        else $error("heading valid dropped without reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && o_out_valid && !i_out_ready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
